FILE: sv/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg: shared types, constants and tables for the PLL AM/FM demodulator
// Holds the configuration record, controller-to-datapath command codes and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pdm_pkg;

  localparam int DEF_SAMPLE_WIDTH  = 16;
  localparam int DEF_PHASE_WIDTH   = 32;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam int IDX_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_DEMOD_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ_LOW   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ_HIGH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FM_GAIN    = 3'd5;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_AM   = 2'd1;
  localparam logic [1:0] MODE_SAM  = 2'd2;
  localparam logic [1:0] MODE_FM   = 2'd3;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_ROT_PRE  = 5'd2;
  localparam logic [4:0] OP_ROT_IT   = 5'd3;
  localparam logic [4:0] OP_GAIN_X   = 5'd4;
  localparam logic [4:0] OP_GAIN_Y   = 5'd5;
  localparam logic [4:0] OP_VEC_PRE  = 5'd6;
  localparam logic [4:0] OP_VEC_IT   = 5'd7;
  localparam logic [4:0] OP_MAG      = 5'd8;
  localparam logic [4:0] OP_ERR      = 5'd9;
  localparam logic [4:0] OP_FREQ     = 5'd10;
  localparam logic [4:0] OP_PHASE    = 5'd11;
  localparam logic [4:0] OP_DC_UPD   = 5'd12;
  localparam logic [4:0] OP_DC_OUT   = 5'd13;
  localparam logic [4:0] OP_AFC_UPD  = 5'd14;
  localparam logic [4:0] OP_FM_SCALE = 5'd15;
  localparam logic [4:0] OP_FM_TWOPI = 5'd16;
  localparam logic [4:0] OP_FM_OUT   = 5'd17;
  localparam logic [4:0] OP_PASS     = 5'd18;
  localparam logic [4:0] OP_AM_OUT   = 5'd19;
  localparam logic [4:0] OP_OUT_LOAD = 5'd20;

  localparam logic [21:0] INV_GAIN   = 22'd2547003;
  localparam logic [10:0] DC_COEF    = 11'd1049;
  localparam logic [13:0] AFC_COEF   = 14'd10486;
  localparam logic [15:0] TWO_PI_Q13 = 16'd51472;

  typedef struct packed {
    logic [1:0]         demod_mode;
    logic [16:0]        prop_gain;
    logic [23:0]        integ_gain;
    logic signed [31:0] freq_low_limit;
    logic signed [31:0] freq_high_limit;
    logic [15:0]        fm_gain;
  } pdm_cfg_t;

  typedef struct packed {
    logic [4:0]       op;
    logic [IDX_W-1:0] idx;
  } pdm_cmd_t;

  function automatic logic [31:0] pdm_atan(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/pll_am_fm_demodulator_unit.sv
// ----------------------------------------------------------------------------
// pll_am_fm_demodulator_unit: PLL based AM and FM demodulator
// Takes complex I/Q samples and delivers one demodulated sample per item.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_ group (I and Q); one result item per input
// leaves on the m_ group with the demodulated value on both lanes, or the
// unchanged I and Q in passthrough mode.
// The block works on one item at a time: it takes a new item only from the
// idle state, after the previous result has been loaded. Except in
// passthrough, the work is done mainly by the single shared CORDIC unit,
// which advances one stage per cycle. In synchronous AM and FM it first
// rotates by the NCO phase and then measures angle and magnitude; in AM
// magnitude mode it only measures angle and magnitude.
// A finished result sits in the output register while the next item is
// accepted and processed; if the receiver still stalls when the next result
// is done, the block waits before taking another item.
// Synchronous reset clears the NCO phase and frequency, the DC and AFC means,
// drops any pending result and restores the register defaults. The user
// writes registers via cfg_we/cfg_addr/cfg_data only while idle; unchecked.
// ----------------------------------------------------------------------------
module pll_am_fm_demodulator_unit #(
  parameter int SAMPLE_WIDTH  = pdm_pkg::DEF_SAMPLE_WIDTH,
  parameter int PHASE_WIDTH   = pdm_pkg::DEF_PHASE_WIDTH,
  parameter int CORDIC_STAGES = pdm_pkg::DEF_CORDIC_STAGES,
  localparam int TDW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [TDW-1:0]                  s_tdata,   // sample_i, sample_q
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [TDW-1:0]                  m_tdata,   // out_real, out_imag
  input  logic                            cfg_we,
  input  logic [pdm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pdm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  pdm_cfg_t               cfg;
  pdm_cmd_t               cmd;
  logic signed [SW-1:0]   out_real, out_imag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.demod_mode      <= MODE_PASS;
      cfg.prop_gain       <= 17'd1285;
      cfg.integ_gain      <= 24'd1611;
      cfg.freq_low_limit  <= 32'sh80000000;
      cfg.freq_high_limit <= 32'sh7FFFFFFF;
      cfg.fm_gain         <= 16'd3520;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEMOD_MODE: cfg.demod_mode      <= cfg_data[1:0];
        REG_PROP_GAIN:  cfg.prop_gain       <= cfg_data[16:0];
        REG_INTEG_GAIN: cfg.integ_gain      <= cfg_data[23:0];
        REG_FREQ_LOW:   cfg.freq_low_limit  <= cfg_data;
        REG_FREQ_HIGH:  cfg.freq_high_limit <= cfg_data;
        REG_FM_GAIN:    cfg.fm_gain         <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  pdm_ctrl #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .mode     (cfg.demod_mode),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd)
  );

  pdm_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .in_i    (s_tdata[SW-1:0]),
    .in_q    (s_tdata[2*SW-1:SW]),
    .out_real(out_real),
    .out_imag(out_imag)
  );

  assign m_tdata = TDW'({out_imag, out_real});

endmodule

FILE: sv/pdm_ctrl.sv
// ----------------------------------------------------------------------------
// pdm_ctrl: sequencer of the PLL AM/FM demodulator
// Steps the datapath through the CORDIC iterations, the loop update and the
// output computation, and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module pdm_ctrl #(
  parameter int CORDIC_STAGES = pdm_pkg::DEF_CORDIC_STAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        mode,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pdm_pkg::pdm_cmd_t cmd
);
  import pdm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ROT_PRE = 4'd1;
  localparam logic [3:0] S_ROT_IT  = 4'd2;
  localparam logic [3:0] S_GAIN_X  = 4'd3;
  localparam logic [3:0] S_GAIN_Y  = 4'd4;
  localparam logic [3:0] S_VEC_PRE = 4'd5;
  localparam logic [3:0] S_VEC_IT  = 4'd6;
  localparam logic [3:0] S_MAG     = 4'd7;
  localparam logic [3:0] S_ERR     = 4'd8;
  localparam logic [3:0] S_FREQ    = 4'd9;
  localparam logic [3:0] S_PHASE   = 4'd10;
  localparam logic [3:0] S_POST1   = 4'd11;
  localparam logic [3:0] S_POST2   = 4'd12;
  localparam logic [3:0] S_POST3   = 4'd13;
  localparam logic [3:0] S_POST4   = 4'd14;
  localparam logic [3:0] S_WAIT    = 4'd15;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_STAGES - 1);

  logic [3:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid_next;
  logic             accept;
  logic             last_it;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_it  = (idx == LAST_IDX);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op = OP_LOAD;
          case (mode)
            MODE_PASS: state_next = S_POST1;
            MODE_AM:   state_next = S_VEC_PRE;
            default:   state_next = S_ROT_PRE;
          endcase
        end
      end
      S_ROT_PRE: begin
        cmd.op     = OP_ROT_PRE;
        idx_next   = '0;
        state_next = S_ROT_IT;
      end
      S_ROT_IT: begin
        cmd.op   = OP_ROT_IT;
        idx_next = idx + 1'b1;
        if (last_it) begin
          state_next = S_GAIN_X;
        end
      end
      S_GAIN_X: begin
        cmd.op     = OP_GAIN_X;
        state_next = S_GAIN_Y;
      end
      S_GAIN_Y: begin
        cmd.op     = OP_GAIN_Y;
        state_next = S_VEC_PRE;
      end
      S_VEC_PRE: begin
        cmd.op     = OP_VEC_PRE;
        idx_next   = '0;
        state_next = S_VEC_IT;
      end
      S_VEC_IT: begin
        cmd.op   = OP_VEC_IT;
        idx_next = idx + 1'b1;
        if (last_it) begin
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        state_next = (mode == MODE_AM) ? S_POST1 : S_ERR;
      end
      S_ERR: begin
        cmd.op     = OP_ERR;
        state_next = S_FREQ;
      end
      S_FREQ: begin
        cmd.op     = OP_FREQ;
        state_next = S_PHASE;
      end
      S_PHASE: begin
        cmd.op     = OP_PHASE;
        state_next = S_POST1;
      end
      S_POST1: begin
        case (mode)
          MODE_PASS: begin
            cmd.op     = OP_PASS;
            state_next = S_WAIT;
          end
          MODE_AM: begin
            cmd.op     = OP_AM_OUT;
            state_next = S_WAIT;
          end
          MODE_SAM: begin
            cmd.op     = OP_DC_UPD;
            state_next = S_POST2;
          end
          default: begin
            cmd.op     = OP_AFC_UPD;
            state_next = S_POST2;
          end
        endcase
      end
      S_POST2: begin
        if (mode == MODE_SAM) begin
          cmd.op     = OP_DC_OUT;
          state_next = S_WAIT;
        end else begin
          cmd.op     = OP_FM_SCALE;
          state_next = S_POST3;
        end
      end
      S_POST3: begin
        cmd.op     = OP_FM_TWOPI;
        state_next = S_POST4;
      end
      S_POST4: begin
        cmd.op     = OP_FM_OUT;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.op == OP_OUT_LOAD) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item did not start processing");

  a_rot_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT_IT && last_it) |=> state == S_GAIN_X)
    else $error("rotation did not end after the last stage");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result was dropped");

endmodule

FILE: sv/pdm_datapath.sv
// ----------------------------------------------------------------------------
// pdm_datapath: arithmetic of the PLL AM/FM demodulator
// Shared iterative CORDIC for rotation and vectoring, the second order loop
// state, the DC and AFC filters and the output register.
// ----------------------------------------------------------------------------
module pdm_datapath #(
  parameter int SAMPLE_WIDTH = pdm_pkg::DEF_SAMPLE_WIDTH,
  parameter int PHASE_WIDTH  = pdm_pkg::DEF_PHASE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pdm_pkg::pdm_cmd_t              cmd,
  input  pdm_pkg::pdm_cfg_t              cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  output logic signed [SAMPLE_WIDTH-1:0] out_real,
  output logic signed [SAMPLE_WIDTH-1:0] out_imag
);
  import pdm_pkg::*;

  localparam int SW       = SAMPLE_WIDTH;
  localparam int PW       = PHASE_WIDTH;
  localparam int G        = 40 - SW;
  localparam int CW       = 44;
  localparam int DC_SHIFT = 9;
  localparam int DC_FRAC  = 31 - SW;
  localparam int MW       = SW + 2;
  localparam int DW       = PW + 1;
  localparam int FW       = 36;
  localparam int RW       = CW - DC_SHIFT;
  localparam int DCW      = 36;
  localparam int AW       = 34;
  localparam int FSW      = 44;
  localparam int FTW      = 61;
  localparam int FM_SHIFT = PW + 14 - SW;

  function automatic logic [SW-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic [SW-1:0]      r;
    hi = 64'sd1 <<< (SW - 1);
    hi = hi - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      r = hi[SW-1:0];
    end else if (v < lo) begin
      r = lo[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  logic signed [CW-1:0]  x, y, mag;
  logic signed [33:0]    zr;
  logic [31:0]           zv;
  logic                  zero;
  logic signed [RW-1:0]  r;
  logic signed [DW-1:0]  diff;
  logic signed [31:0]    fr, freq;
  logic [PW-1:0]         phase;
  logic signed [DCW-1:0] dc;
  logic signed [AW-1:0]  afc;
  logic signed [FSW-1:0] fs;
  logic signed [FTW-1:0] ft;
  logic [SW-1:0]         res_r, res_i;

  logic signed [CW-1:0]  xs, ys, gsel, gn;
  logic signed [66:0]    gp;
  logic [31:0]           atan_v, rot_a;
  logic signed [PW-1:0]  err;
  logic signed [MW-1:0]  m;
  logic signed [MW+PW-1:0] pm;
  logic signed [DW+24:0] ip;
  logic signed [FW-1:0]  fsum, fc;
  logic signed [DW+17:0] pp;
  logic signed [DCW:0]   dd;
  logic signed [DCW+12:0] dp;
  logic signed [AW:0]    ad;
  logic signed [AW+15:0] ap;
  logic signed [AW+17:0] sp;
  logic signed [FW-1:0]  lo_ext, hi_ext;

  assign xs     = x >>> cmd.idx;
  assign ys     = y >>> cmd.idx;
  assign atan_v = pdm_atan(cmd.idx);
  assign gsel   = (cmd.op == OP_GAIN_Y) ? y : x;
  assign gp     = 67'(gsel) * 67'($signed({1'b0, INV_GAIN}));
  assign gn     = gp[22 +: CW];
  assign rot_a  = 32'd0 - (32'(phase) << (32 - PW));

  assign err    = zv[31 -: PW];
  assign m      = mag[G +: MW];
  assign pm     = (MW+PW)'(m) * (MW+PW)'(err);

  assign ip     = (DW+25)'($signed({1'b0, cfg.integ_gain})) * (DW+25)'(diff);
  assign fsum   = FW'(freq) + FW'($signed(ip[24 +: DW+1]));
  assign lo_ext = FW'(cfg.freq_low_limit);
  assign hi_ext = FW'(cfg.freq_high_limit);

  always_comb begin
    fc = fsum;
    if (fc < lo_ext) begin
      fc = lo_ext;
    end
    if (fc > hi_ext) begin
      fc = hi_ext;
    end
  end

  assign pp = (DW+18)'($signed({1'b0, cfg.prop_gain})) * (DW+18)'(diff);
  assign dd = (DCW+1)'(r) - (DCW+1)'(dc);
  assign dp = (DCW+13)'(dd) * (DCW+13)'($signed({1'b0, DC_COEF}));
  assign ad = (AW+1)'(fr) - (AW+1)'(afc);
  assign ap = (AW+16)'(ad) * (AW+16)'($signed({1'b0, AFC_COEF}));
  assign sp = (AW+18)'(ad) * (AW+18)'($signed({1'b0, cfg.fm_gain}));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      freq  <= '0;
      dc    <= '0;
      afc   <= '0;
    end else begin
      case (cmd.op)
        OP_PHASE: begin
          freq  <= fr;
          phase <= phase + fr[PW-1:0] + pp[16 +: PW];
        end
        OP_DC_UPD: begin
          dc <= dc + dp[20 +: DCW];
        end
        OP_AFC_UPD: begin
          afc <= afc + ap[20 +: AW];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x     <= CW'(in_i) <<< G;
        y     <= CW'(in_q) <<< G;
        res_r <= in_i;
        res_i <= in_q;
      end
      OP_ROT_PRE: begin
        if (rot_a[31:30] == 2'b01 || rot_a[31:30] == 2'b10) begin
          x  <= -x;
          y  <= -y;
          zr <= 34'($signed(rot_a + 32'h80000000));
        end else begin
          zr <= 34'($signed(rot_a));
        end
      end
      OP_ROT_IT: begin
        if (!zr[33]) begin
          x  <= x - ys;
          y  <= y + xs;
          zr <= zr - 34'(atan_v);
        end else begin
          x  <= x + ys;
          y  <= y - xs;
          zr <= zr + 34'(atan_v);
        end
      end
      OP_GAIN_X: begin
        x <= gn;
        r <= gn[DC_SHIFT +: RW];
      end
      OP_GAIN_Y: begin
        y <= gn;
      end
      OP_VEC_PRE: begin
        zero <= (x == '0) && (y == '0);
        if (x[CW-1]) begin
          if (!y[CW-1]) begin
            x  <= y;
            y  <= -x;
            zv <= 32'h40000000;
          end else begin
            x  <= -y;
            y  <= x;
            zv <= 32'hC0000000;
          end
        end else begin
          zv <= 32'd0;
        end
      end
      OP_VEC_IT: begin
        if (!y[CW-1]) begin
          x  <= x + ys;
          y  <= y - xs;
          zv <= zv + atan_v;
        end else begin
          x  <= x - ys;
          y  <= y + xs;
          zv <= zv - atan_v;
        end
      end
      OP_MAG: begin
        if (zero) begin
          mag <= '0;
          zv  <= 32'd0;
        end else begin
          mag <= gn;
        end
      end
      OP_ERR: begin
        if (cfg.demod_mode == MODE_SAM) begin
          diff <= pm[SW-1 +: DW];
        end else begin
          diff <= DW'(err);
        end
      end
      OP_FREQ: begin
        fr <= fc[31:0];
      end
      OP_DC_OUT: begin
        res_r <= sat_out(64'(dd >>> DC_FRAC));
        res_i <= sat_out(64'(dd >>> DC_FRAC));
      end
      OP_FM_SCALE: begin
        fs <= sp[8 +: FSW];
      end
      OP_FM_TWOPI: begin
        ft <= FTW'(fs) * FTW'($signed({1'b0, TWO_PI_Q13}));
      end
      OP_FM_OUT: begin
        res_r <= sat_out(64'(ft >>> FM_SHIFT));
        res_i <= sat_out(64'(ft >>> FM_SHIFT));
      end
      OP_AM_OUT: begin
        res_r <= sat_out(64'(mag >>> G));
        res_i <= sat_out(64'(mag >>> G));
      end
      OP_OUT_LOAD: begin
        out_real <= res_r;
        out_imag <= res_i;
      end
      default: begin
      end
    endcase
  end

endmodule
